@@ rtl/core/hrhf_pkg.sv @@
package hrhf_pkg;

  localparam int unsigned MaxHdrReset = 8192;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChColon = 8'd58;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam int unsigned LenNameSize = 14;

  typedef enum logic [2:0] {
    KIND_IGNORED = 3'd0,
    KIND_METHOD  = 3'd1,
    KIND_PATH    = 3'd2,
    KIND_NAME    = 3'd3,
    KIND_VALUE   = 3'd4,
    KIND_HDR_END = 3'd5,
    KIND_BODY    = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_BODY    = 4'b0010,
    PH_DONE    = 4'b0100,
    PH_STOPPED = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0]  data;
    kind_t       kind;
    logic        line_done;
    logic        request_end;
    logic [31:0] body_length;
  } result_t;

  function automatic logic [7:0] len_name_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:  c = "C";
      4'd1:  c = "o";
      4'd2:  c = "n";
      4'd3:  c = "t";
      4'd4:  c = "e";
      4'd5:  c = "n";
      4'd6:  c = "t";
      4'd7:  c = "-";
      4'd8:  c = "L";
      4'd9:  c = "e";
      4'd10: c = "n";
      4'd11: c = "g";
      4'd12: c = "t";
      4'd13: c = "h";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/core/hrhf_classify.sv @@
module hrhf_classify
  import hrhf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic [15:0]   max_hdr,
  input  logic          step,
  input  logic [7:0]    data,
  output result_t       res
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  term_r, term_nxt;
  logic        saw_cr_r, saw_cr_nxt;
  logic        first_r, first_nxt;
  logic [1:0]  fpos_r, fpos_nxt;
  logic [15:0] hcnt_r, hcnt_nxt;
  logic [3:0]  midx_r, midx_nxt;
  logic        match_r, match_nxt;
  logic [1:0]  dst_r, dst_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] rcv_r, rcv_nxt;

  logic [16:0] cnt_next;
  logic        ws, dig;
  logic [35:0] acc_mul;
  logic [31:0] rcv_inc;

  assign cnt_next = {1'b0, hcnt_r} + 17'd1;
  assign ws  = (data == ChSpace) || (data >= 8'd9 && data <= 8'd13);
  assign dig = (data >= 8'd48 && data <= 8'd57);
  // acc*10 + digit via shifts; saturate if top bits set
  assign acc_mul = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {32'd0, data[3:0]};
  assign rcv_inc = (rcv_r == 32'hFFFF_FFFF) ? rcv_r : rcv_r + 32'd1;

  always_comb begin
    phase_nxt = phase_r; term_nxt = term_r; saw_cr_nxt = saw_cr_r;
    first_nxt = first_r; fpos_nxt = fpos_r; hcnt_nxt = hcnt_r;
    midx_nxt = midx_r; match_nxt = match_r; dst_nxt = dst_r;
    acc_nxt = acc_r; len_nxt = len_r; rcv_nxt = rcv_r;
    res.data = data;
    res.kind = KIND_IGNORED;
    res.line_done = 1'b0;
    res.request_end = 1'b0;
    res.body_length = len_r;
    unique case (phase_r)
      PH_BODY: begin
        res.kind = KIND_BODY;
        rcv_nxt = rcv_inc;
        if (rcv_inc >= len_r) begin
          res.request_end = 1'b1;
          phase_nxt = PH_DONE;
        end
      end
      PH_HEADER: begin
        if (((term_r == 3'd0 || term_r == 3'd2) && data == ChCr) ||
            ((term_r == 3'd1 || term_r == 3'd3) && data == ChLf))
          term_nxt = term_r + 3'd1;
        else
          term_nxt = 3'd0;

        priority if (data == ChCr) begin
          saw_cr_nxt = 1'b1;
        end else if (data == ChLf && saw_cr_r) begin
          saw_cr_nxt = 1'b0;
          if (!first_r) first_nxt = 1'b1;
          else if (match_r && midx_r == 4'(LenNameSize)) len_nxt = acc_r;
          fpos_nxt = 2'd0; midx_nxt = 4'd0; match_nxt = 1'b1;
          dst_nxt = 2'd0; acc_nxt = 32'd0;
          res.line_done = 1'b1;
        end else begin
          saw_cr_nxt = 1'b0;
          if (!first_r) begin
            if (fpos_r == 2'd0) begin
              if (data == ChSpace) fpos_nxt = 2'd1; else res.kind = KIND_METHOD;
            end else if (fpos_r == 2'd1) begin
              if (data == ChSpace) fpos_nxt = 2'd2; else res.kind = KIND_PATH;
            end
          end else begin
            if (fpos_r == 2'd0) begin
              if (data == ChColon) fpos_nxt = 2'd1;
              else begin
                res.kind = KIND_NAME;
                if (midx_r < 4'(LenNameSize) && data == len_name_char(midx_r))
                  midx_nxt = midx_r + 4'd1;
                else
                  match_nxt = 1'b0;
              end
            end else if (fpos_r == 2'd1) begin
              fpos_nxt = 2'd2;
            end else begin
              res.kind = KIND_VALUE;
              if (dst_r == 2'd0) begin
                if (dig) begin acc_nxt = {28'd0, data[3:0]}; dst_nxt = 2'd1; end
                else if (!ws) dst_nxt = 2'd2;
              end else if (dst_r == 2'd1) begin
                if (dig) acc_nxt = (acc_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                           : acc_mul[31:0];
                else dst_nxt = 2'd2;
              end
            end
          end
        end

        if (term_nxt == 3'd4) begin
          term_nxt = 3'd0;
          res.kind = KIND_HDR_END;
          res.line_done = 1'b0;
          res.body_length = len_nxt;
          if (len_nxt == 32'd0) begin
            res.request_end = 1'b1; phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_BODY; rcv_nxt = 32'd0;
          end
        end else if (cnt_next > {1'b0, max_hdr}) begin
          res.request_end = 1'b1;
          phase_nxt = PH_STOPPED;
        end
        res.body_length = len_nxt;
        hcnt_nxt = cnt_next[16] ? 16'hFFFF : cnt_next[15:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER; term_r <= '0; saw_cr_r <= 1'b0; first_r <= 1'b0;
      fpos_r <= '0; hcnt_r <= '0; midx_r <= '0; match_r <= 1'b1; dst_r <= '0;
      acc_r <= '0; len_r <= '0; rcv_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; term_r <= term_nxt; saw_cr_r <= saw_cr_nxt;
      first_r <= first_nxt; fpos_r <= fpos_nxt; hcnt_r <= hcnt_nxt;
      midx_r <= midx_nxt; match_r <= match_nxt; dst_r <= dst_nxt;
      acc_r <= acc_nxt; len_r <= len_nxt; rcv_r <= rcv_nxt;
    end
  end

endmodule

@@ rtl/core/hrhf_queue.sv @@
module hrhf_queue
  import hrhf_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    pop_valid,
  input  logic    pop,
  output result_t pop_data
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  result_t             mem_r [Depth];
  logic [AW-1:0]       wp_r, rp_r;
  logic [CW-1:0]       cnt_r;

  assign full      = (cnt_r == CW'(Depth));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rp_r];

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= adv(wp_r);
      if (pop)  rp_r <= adv(rp_r);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

@@ rtl/core/http_request_header_framer.sv @@
// Channel  | Ports                                   | Direction
// input    | in_valid, in_ready, in_byte_in          | in
// result   | out_valid, out_ready, out_byte_out,     | out
//          | out_kind, out_line_done,                |
//          | out_request_end, out_body_length        |
// config   | cfg_we, cfg_data (max_header_bytes)     | in
// One byte per cycle sustained while the queue is not full; each item is
// classified in the cycle it is accepted and registered into a 2-entry queue.
// Reset (rst_n low, synchronous) returns the parser to header phase, empties
// the queue and restores max_header_bytes to 8192.
// in_ready drops only when the queue is full; output stalls back up there.
module http_request_header_framer
  import hrhf_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_out,
  output logic [2:0]  out_kind,
  output logic        out_line_done,
  output logic        out_request_end,
  output logic [31:0] out_body_length,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  logic [15:0] max_hdr_r;
  logic        full, step;
  result_t     cls_res, q_res;

  always_ff @(posedge clk) begin
    if (!rst_n) max_hdr_r <= 16'(MaxHdrReset);
    else if (cfg_we) max_hdr_r <= cfg_data;
  end

  assign in_ready = !full;
  assign step     = in_valid && in_ready;

  // front: classify byte and update parse state
  hrhf_classify u_cls (
    .clk, .rst_n, .max_hdr(max_hdr_r), .step, .data(in_byte_in), .res(cls_res)
  );

  // back: result queue decouples output stalls
  hrhf_queue #(.Depth(QDepth)) u_q (
    .clk, .rst_n, .push(step), .push_data(cls_res), .full,
    .pop_valid(out_valid), .pop(out_valid && out_ready), .pop_data(q_res)
  );

  assign out_byte_out    = q_res.data;
  assign out_kind        = q_res.kind;
  assign out_line_done   = q_res.line_done;
  assign out_request_end = q_res.request_end;
  assign out_body_length = q_res.body_length;

  a_byte_pass: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> cls_res.data == in_byte_in) else $error("byte not passed");
  a_hdr_end_no_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_HDR_END) |-> !out_line_done)
    else $error("line_done at header end");
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !full) else $error("ready while full");

endmodule

@@ sim/http_request_header_framer_test.sv @@
module http_request_header_framer_test
  import hrhf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [8*14-1:0] LenText = "Content-Length";

  // One expected output item.
  typedef struct {
    logic [7:0]  data;
    kind_t       kind;
    logic        line_done;
    logic        request_end;
    logic [31:0] body_length;
  } framed_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_in = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte_out;
  logic [2:0]  out_kind;
  logic        out_line_done;
  logic        out_request_end;
  logic [31:0] out_body_length;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = 16'd0;

  http_request_header_framer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_in      (in_byte_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte_out    (out_byte_out),
    .out_kind        (out_kind),
    .out_line_done   (out_line_done),
    .out_request_end (out_request_end),
    .out_body_length (out_body_length),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data)
  );

  always #10 clk = ~clk;

  logic [7:0] byte_queue[$];      // bytes waiting for the driver
  framed_t    framed_queue[$];    // predicted output items, oldest first
  int         errors = 0;
  int         cycles = 0;
  bit         quiet = 1'b0;       // no idling on either side while set
  int         send_gap = 0;
  int         recv_gap = 0;
  int         hold_left = 0;
  logic       hold_kick = 1'b0;

  // Predictor state, mirrors the framer.
  logic [15:0] max_hdr;
  int          term_cnt;
  phase_t      phase_q;
  logic        saw_cr, first_line_done;
  logic [1:0]  field_pos;
  logic [15:0] hdr_cnt;
  logic [3:0]  name_idx;
  logic        name_ok;
  logic [1:0]  digit_st;
  logic [31:0] value_acc, len_reg, rx_count;

  // Append one byte to the stimulus stream.
  function automatic void put_byte(input logic [7:0] b);
    byte_queue.insert(byte_queue.size(), b);
  endfunction

  function automatic void reset_line();
    field_pos = 2'd0;
    name_idx = 4'd0;
    name_ok = 1'b1;
    digit_st = 2'd0;
    value_acc = 32'd0;
  endfunction

  // Classify one accepted byte and queue the output item it causes.
  function automatic void frame_byte(input logic [7:0] b);
    framed_t     r;
    logic [16:0] next_cnt;
    logic [63:0] prod;
    logic        ws, dig;
    r.data = b;
    r.kind = KIND_IGNORED;
    r.line_done = 1'b0;
    r.request_end = 1'b0;
    case (phase_q)
      PH_BODY: begin
        r.kind = KIND_BODY;
        if (rx_count != 32'hFFFF_FFFF) rx_count++;
        if (rx_count >= len_reg) begin
          r.request_end = 1'b1;
          phase_q = PH_DONE;
        end
      end
      PH_HEADER: begin
        next_cnt = {1'b0, hdr_cnt} + 17'd1;
        // CR LF CR LF tracker; anything out of step restarts it
        if (((term_cnt == 0 || term_cnt == 2) && b == ChCr) ||
            ((term_cnt == 1 || term_cnt == 3) && b == ChLf))
          term_cnt++;
        else
          term_cnt = 0;
        if (b == ChCr) begin
          saw_cr = 1'b1;
        end else if (b == ChLf && saw_cr) begin
          saw_cr = 1'b0;
          if (!first_line_done) first_line_done = 1'b1;
          else if (name_ok && name_idx == 4'd14) len_reg = value_acc;
          reset_line();
          r.line_done = 1'b1;
        end else begin
          saw_cr = 1'b0;
          if (!first_line_done) begin
            if (field_pos == 2'd0) begin
              if (b == ChSpace) field_pos = 2'd1;
              else r.kind = KIND_METHOD;
            end else if (field_pos == 2'd1) begin
              if (b == ChSpace) field_pos = 2'd2;
              else r.kind = KIND_PATH;
            end
          end else if (field_pos == 2'd0) begin
            if (b == ChColon) begin
              field_pos = 2'd1;
            end else begin
              r.kind = KIND_NAME;
              if (name_idx < 4'd14 && b == LenText[8*(13-name_idx) +: 8]) name_idx++;
              else name_ok = 1'b0;
            end
          end else if (field_pos == 2'd1) begin
            field_pos = 2'd2;   // the one skipped separator byte
          end else begin
            r.kind = KIND_VALUE;
            ws = (b == ChSpace) || (b >= 8'd9 && b <= 8'd13);
            dig = (b >= "0" && b <= "9");
            if (digit_st == 2'd0) begin
              if (dig) begin
                value_acc = {24'd0, b - 8'd48};
                digit_st = 2'd1;
              end else if (!ws) begin
                digit_st = 2'd2;
              end
            end else if (digit_st == 2'd1) begin
              if (dig) begin
                prod = {32'd0, value_acc} * 64'd10 + {56'd0, b - 8'd48};
                value_acc = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
              end else begin
                digit_st = 2'd2;
              end
            end
          end
        end
        if (term_cnt == 4) begin
          term_cnt = 0;
          r.kind = KIND_HDR_END;
          r.line_done = 1'b0;
          if (len_reg == 32'd0) begin
            r.request_end = 1'b1;
            phase_q = PH_DONE;
          end else begin
            phase_q = PH_BODY;
            rx_count = 32'd0;
          end
        end else if (next_cnt > {1'b0, max_hdr}) begin
          r.request_end = 1'b1;
          phase_q = PH_STOPPED;
        end
        hdr_cnt = next_cnt[16] ? 16'hFFFF : next_cnt[15:0];
      end
      default: ;   // done or stopped: everything ignored
    endcase
    r.body_length = len_reg;
    framed_queue.insert(framed_queue.size(), r);
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (quiet || p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Driver: offers the next byte and keeps it steady until accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) frame_byte(in_byte_in);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_byte_in <= byte_queue.pop_front();
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, so the output queue fills and in_ready drops.
  always @(posedge clk) begin
    if (hold_kick) hold_left <= 300;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Monitor: compares each accepted output item with the oldest prediction.
  always @(posedge clk) begin
    framed_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (framed_queue.size() == 0) begin
          $error("unexpected item: byte_out %0h", out_byte_out);
          errors++;
        end else begin
          e = framed_queue.pop_front();
          if (out_byte_out !== e.data) begin
            $error("byte_out: expected %0h, got %0h", e.data, out_byte_out);
            errors++;
          end
          if (out_kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, out_kind);
            errors++;
          end
          if (out_line_done !== e.line_done) begin
            $error("line_done: expected %0b, got %0b", e.line_done, out_line_done);
            errors++;
          end
          if (out_request_end !== e.request_end) begin
            $error("request_end: expected %0b, got %0b", e.request_end, out_request_end);
            errors++;
          end
          if (out_body_length !== e.body_length) begin
            $error("body_length: expected %0d, got %0d", e.body_length, out_body_length);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_crlf();
    put_byte(ChCr);
    put_byte(ChLf);
  endtask

  // Random byte that never forms a CR (stray CRs are placed on purpose).
  function automatic logic [7:0] no_cr_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == ChCr);
    return b;
  endfunction

  // One header line with random content, ending in CR LF.
  task automatic put_header_line();
    int sel, n;
    logic [7:0] b;
    sel = $urandom_range(99);
    if (sel < 45) begin
      // Content-Length, sometimes with a damaged name or missing colon
      put_str("Content-Length");
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(14);
        if (n < 14) byte_queue[byte_queue.size() - 14 + n] = no_cr_byte();
        else put_byte("x");
      end
      if ($urandom_range(9) != 0) begin
        put_byte(ChColon);
        put_byte(($urandom_range(3) == 0) ? no_cr_byte() : ChSpace);
        n = $urandom_range(3);
        repeat (n) begin
          case ($urandom_range(4))
            0: put_byte(8'd9);
            1: put_byte(8'd11);
            2: put_byte(8'd12);
            3: put_byte(ChLf);
            default: put_byte(ChSpace);
          endcase
        end
        n = ($urandom_range(7) == 0) ? $urandom_range(14, 10) : $urandom_range(4);
        repeat (n) put_byte(8'(48 + $urandom_range(9)));
        if ($urandom_range(3) == 0) begin
          n = $urandom_range(3);
          repeat (n) put_byte(no_cr_byte());
        end
      end
    end else if (sel < 85) begin
      n = $urandom_range(8);
      repeat (n) put_byte(no_cr_byte());
      if ($urandom_range(4) != 0) put_byte(ChColon);
      n = $urandom_range(10);
      repeat (n) put_byte(no_cr_byte());
    end else begin
      // noise with stray CRs that are not followed by LF
      n = $urandom_range(10, 1);
      repeat (n) begin
        if ($urandom_range(3) == 0) begin
          put_byte(ChCr);
          do b = 8'($urandom_range(255)); while (b == ChLf);
          put_byte(b);
        end else begin
          put_byte(no_cr_byte());
        end
      end
      put_byte(8'd65);
    end
    put_crlf();
  endtask

  task automatic wait_idle();
    while (byte_queue.size() > 0 || in_valid || framed_queue.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_hdr = v;
  endtask

  initial begin
    int body_len;
    max_hdr = 16'd8192;
    term_cnt = 0;
    phase_q = PH_HEADER;
    saw_cr = 1'b0;
    first_line_done = 1'b0;
    hdr_cnt = 16'd0;
    len_reg = 32'd0;
    rx_count = 32'd0;
    reset_line();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: byte extremes in the method, path, trailer, lone LF,
    // stray CR inside a name, bare colon line, run under the reset limit.
    put_byte(8'h00);
    put_byte(8'hFF);
    put_str(" /p v");
    put_crlf();
    put_byte(ChLf);
    put_str("X");
    put_byte(ChCr);
    put_str("Y: 7");
    put_crlf();
    put_str(":");
    put_crlf();
    wait_idle();

    write_limit(16'hFFFF);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    while (byte_queue.size() < 550) put_header_line();
    wait_idle();

    write_limit(16'd30000);
    quiet = 1'b1;
    while (byte_queue.size() < 150) put_header_line();
    wait_idle();
    quiet = 1'b0;
    while (byte_queue.size() < 300) put_header_line();

    // Last length line wins, then the blank line ends the header.
    body_len = $urandom_range(60, 20);
    put_str($sformatf("Content-Length: %0d", body_len));
    put_crlf();
    put_crlf();
    repeat (body_len) put_byte(8'($urandom_range(255)));
    wait_idle();

    // After the request end everything is ignored; limit set to 1.
    write_limit(16'd1);
    repeat (60) put_byte(8'($urandom_range(255)));
    wait_idle();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/hrhf_pkg.sv
rtl/core/hrhf_classify.sv
rtl/core/hrhf_queue.sv
rtl/core/http_request_header_framer.sv
sim/http_request_header_framer_test.sv
